[hw/rtl/sccb_pkg.sv]
package sccb_pkg;

  // request function codes
  localparam logic [1:0] FUNC_TICK  = 2'd0;
  localparam logic [1:0] FUNC_WRITE = 2'd1;
  localparam logic [1:0] FUNC_READ  = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_SLAVE_ADDR  = 2'd0;
  localparam logic [1:0] CFG_RETRY_LIMIT = 2'd1;
  localparam logic [1:0] CFG_PHASE_TICKS = 2'd2;

  // configuration reset values
  localparam logic [7:0]  SLAVE_ADDR_RESET  = 8'h42;
  localparam logic [3:0]  RETRY_LIMIT_RESET = 4'd3;
  localparam logic [15:0] PHASE_TICKS_RESET = 16'd1;

  // byte slots of a transfer
  localparam logic [1:0] BYTE_SLAVE_WR = 2'd0;
  localparam logic [1:0] BYTE_REG_ADDR = 2'd1;
  localparam logic [1:0] BYTE_REG_VAL  = 2'd2;
  localparam logic [1:0] BYTE_SLAVE_RD = 2'd3;

  // bit count at the end of a byte, and the nack marker for the stop
  localparam logic [3:0] BITS_PER_BYTE = 4'd8;
  localparam logic [3:0] NACK_MARK     = 4'd1;

  // bus sequencer phases
  typedef enum logic [13:0] {
    PH_IDLE      = 14'b00000000000001,
    PH_START_A   = 14'b00000000000010,
    PH_START_B   = 14'b00000000000100,
    PH_BIT_SET   = 14'b00000000001000,
    PH_BIT_HIGH  = 14'b00000000010000,
    PH_ACK_SET   = 14'b00000000100000,
    PH_ACK_HIGH  = 14'b00000001000000,
    PH_RD_LOW    = 14'b00000010000000,
    PH_RD_HIGH   = 14'b00000100000000,
    PH_NACK_LOW  = 14'b00001000000000,
    PH_NACK_HIGH = 14'b00010000000000,
    PH_STOP_A    = 14'b00100000000000,
    PH_STOP_B    = 14'b01000000000000,
    PH_STOP_C    = 14'b10000000000000
  } phase_t;

  // one tick request
  typedef struct packed {
    logic [1:0] func;
    logic [7:0] reg_addr;
    logic [7:0] reg_value;
    logic       sda_in;
    logic       scl_in;
  } sccb_in_t;

  // line and status result of one tick
  typedef struct packed {
    logic       sda_drive_low;
    logic       scl_drive_low;
    logic       busy_res;
    logic       done_res;
    logic       success;
    logic [7:0] read_data;
  } sccb_out_t;

endpackage

[hw/rtl/sccb_register_access_master.sv]
// channel  | direction | handshake            | payload
// in       | input     | in_valid / in_ready  | in_req  (sccb_in_t: one tick)
// out      | output    | out_valid / out_ready| out_res (sccb_out_t: lines, status)
// cfg      | input     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// One request per cycle unless the result stalls, one registered result per request.
// The phase sequencer takes a single registered step per accepted request.
// Reset (rst, synchronous) puts the sequencer in idle and loads register defaults.
// A result that is not taken holds out_res and stalls in_ready in the same cycle.
// The configuration channel is always ready.
module sccb_register_access_master (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  sccb_pkg::sccb_in_t  in_req,
  output logic                out_valid,
  input  logic                out_ready,
  output sccb_pkg::sccb_out_t out_res,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [15:0]         cfg_data
);
  import sccb_pkg::*;

  // configuration registers
  logic [7:0]  slave_addr;
  logic [3:0]  retry_limit;
  logic [15:0] phase_ticks;

  // sequencer state
  phase_t      phase, phase_next;
  logic [15:0] phase_timer, phase_timer_next;
  logic [3:0]  bit_count, bit_count_next;
  logic [1:0]  byte_index, byte_index_next;
  logic [7:0]  shift_reg, shift_reg_next;
  logic [3:0]  attempt_count, attempt_count_next;
  logic        op_is_read, op_is_read_next;
  logic [7:0]  addr_latch, addr_latch_next;
  logic [7:0]  value_latch, value_latch_next;
  logic [7:0]  read_byte, read_byte_next;
  logic        done, ok;

  logic [15:0] ticks;
  logic [16:0] timer_inc;
  logic        in_fire;

  function automatic logic scl_released(input phase_t ph);
    return (ph == PH_START_A) || (ph == PH_BIT_HIGH) || (ph == PH_ACK_HIGH) ||
           (ph == PH_RD_HIGH) || (ph == PH_NACK_HIGH) || (ph == PH_STOP_B) ||
           (ph == PH_STOP_C) || (ph == PH_IDLE);
  endfunction

  function automatic logic [7:0] byte_for(input logic [1:0] idx, input logic [7:0] saddr,
                                          input logic [7:0] raddr, input logic [7:0] rval);
    logic [7:0] b;
    unique case (idx)
      BYTE_SLAVE_WR: b = saddr;
      BYTE_REG_ADDR: b = raddr;
      BYTE_REG_VAL:  b = rval;
      default:       b = saddr + 8'd1;
    endcase
    return b;
  endfunction

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid || out_ready;
  assign in_fire   = in_valid && in_ready;

  // zero phase ticks behaves as one
  assign ticks     = (phase_ticks == 16'd0) ? 16'd1 : phase_ticks;
  assign timer_inc = {1'b0, phase_timer} + 17'd1;

  // next state for one tick
  always_comb begin
    phase_next         = phase;
    phase_timer_next   = phase_timer;
    bit_count_next     = bit_count;
    byte_index_next    = byte_index;
    shift_reg_next     = shift_reg;
    attempt_count_next = attempt_count;
    op_is_read_next    = op_is_read;
    addr_latch_next    = addr_latch;
    value_latch_next   = value_latch;
    read_byte_next     = read_byte;
    done               = 1'b0;
    ok                 = 1'b0;

    if (phase == PH_IDLE) begin
      if (in_req.func == FUNC_WRITE || in_req.func == FUNC_READ) begin
        op_is_read_next    = (in_req.func == FUNC_READ);
        addr_latch_next    = in_req.reg_addr;
        value_latch_next   = in_req.reg_value;
        attempt_count_next = 4'd0;
        byte_index_next    = BYTE_SLAVE_WR;
        bit_count_next     = 4'd0;
        phase_timer_next   = 16'd0;
        phase_next         = PH_START_A;
      end
    end else if (scl_released(phase) && !in_req.scl_in) begin
      // slave stretches the clock
      phase_timer_next = 16'd0;
    end else if (timer_inc < {1'b0, ticks}) begin
      phase_timer_next = timer_inc[15:0];
    end else begin
      phase_timer_next = 16'd0;
      unique case (phase)
        PH_START_A: phase_next = PH_START_B;
        PH_START_B: begin
          shift_reg_next = byte_for(byte_index, slave_addr, addr_latch, value_latch);
          bit_count_next = 4'd0;
          phase_next     = PH_BIT_SET;
        end
        PH_BIT_SET: phase_next = PH_BIT_HIGH;
        PH_BIT_HIGH: begin
          shift_reg_next = {shift_reg[6:0], 1'b0};
          bit_count_next = bit_count + 4'd1;
          phase_next     = (bit_count_next >= BITS_PER_BYTE) ? PH_ACK_SET : PH_BIT_SET;
        end
        PH_ACK_SET: phase_next = PH_ACK_HIGH;
        PH_ACK_HIGH: begin
          priority if (in_req.sda_in) begin
            bit_count_next = NACK_MARK;
            phase_next     = PH_STOP_A;
          end else if (byte_index == BYTE_SLAVE_RD) begin
            shift_reg_next = 8'd0;
            bit_count_next = 4'd0;
            phase_next     = PH_RD_LOW;
          end else if ((op_is_read && byte_index == BYTE_REG_ADDR) ||
                       byte_index == BYTE_REG_VAL) begin
            bit_count_next = 4'd0;
            phase_next     = PH_STOP_A;
          end else begin
            byte_index_next = byte_index + 2'd1;
            shift_reg_next  = byte_for(byte_index_next, slave_addr, addr_latch,
                                       value_latch);
            bit_count_next  = 4'd0;
            phase_next      = PH_BIT_SET;
          end
        end
        PH_RD_LOW: phase_next = PH_RD_HIGH;
        PH_RD_HIGH: begin
          shift_reg_next = {shift_reg[6:0], in_req.sda_in};
          bit_count_next = bit_count + 4'd1;
          phase_next     = (bit_count_next >= BITS_PER_BYTE) ? PH_NACK_LOW : PH_RD_LOW;
        end
        PH_NACK_LOW: phase_next = PH_NACK_HIGH;
        PH_NACK_HIGH: begin
          bit_count_next = 4'd0;
          phase_next     = PH_STOP_A;
        end
        PH_STOP_A: phase_next = PH_STOP_B;
        PH_STOP_B: phase_next = PH_STOP_C;
        PH_STOP_C: begin
          priority if (bit_count == NACK_MARK) begin
            if (attempt_count >= retry_limit) begin
              done       = 1'b1;
              phase_next = PH_IDLE;
            end else begin
              attempt_count_next = attempt_count + 4'd1;
              byte_index_next    = BYTE_SLAVE_WR;
              phase_next         = PH_START_A;
            end
          end else if (op_is_read && byte_index == BYTE_REG_ADDR) begin
            // register selected, restart with the read address
            byte_index_next = BYTE_SLAVE_RD;
            phase_next      = PH_START_A;
          end else begin
            if (op_is_read) begin
              read_byte_next = shift_reg;
            end
            done       = 1'b1;
            ok         = 1'b1;
            phase_next = PH_IDLE;
          end
          bit_count_next = 4'd0;
        end
        default: phase_next = PH_IDLE;
      endcase
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      slave_addr  <= SLAVE_ADDR_RESET;
      retry_limit <= RETRY_LIMIT_RESET;
      phase_ticks <= PHASE_TICKS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_SLAVE_ADDR:  slave_addr  <= cfg_data[7:0];
        CFG_RETRY_LIMIT: retry_limit <= cfg_data[3:0];
        CFG_PHASE_TICKS: phase_ticks <= cfg_data;
        default: ;
      endcase
    end
  end

  // sequencer state update on each accepted tick
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      phase_timer   <= 16'd0;
      bit_count     <= 4'd0;
      byte_index    <= BYTE_SLAVE_WR;
      shift_reg     <= 8'd0;
      attempt_count <= 4'd0;
      op_is_read    <= 1'b0;
      addr_latch    <= 8'd0;
      value_latch   <= 8'd0;
      read_byte     <= 8'd0;
    end else if (in_fire) begin
      phase         <= phase_next;
      phase_timer   <= phase_timer_next;
      bit_count     <= bit_count_next;
      byte_index    <= byte_index_next;
      shift_reg     <= shift_reg_next;
      attempt_count <= attempt_count_next;
      op_is_read    <= op_is_read_next;
      addr_latch    <= addr_latch_next;
      value_latch   <= value_latch_next;
      read_byte     <= read_byte_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_res.sda_drive_low <= (phase_next == PH_START_A) || (phase_next == PH_START_B) ||
                               (phase_next == PH_STOP_A) || (phase_next == PH_STOP_B) ||
                               (((phase_next == PH_BIT_SET) || (phase_next == PH_BIT_HIGH))
                                && !shift_reg_next[7]);
      out_res.scl_drive_low <= !scl_released(phase_next);
      out_res.busy_res      <= (phase_next != PH_IDLE);
      out_res.done_res      <= done;
      out_res.success       <= ok;
      out_res.read_data     <= read_byte_next;
    end
  end

endmodule

[hw/rtl/sccb_checker.sv]
module sccb_checker (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input sccb_pkg::sccb_out_t out_res
);
  import sccb_pkg::*;

  // every accepted request yields a result on the next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> out_valid)
    else $error("accepted request gave no result");

  // a finishing command is no longer busy
  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_res.done_res |-> !out_res.busy_res)
    else $error("done reported while busy");

  // success only comes with done
  a_success_with_done: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_res.success |-> out_res.done_res)
    else $error("success without done");

  // an idle master releases both lines
  a_idle_released: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_res.busy_res |-> !out_res.sda_drive_low && !out_res.scl_drive_low)
    else $error("idle master drives a line");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_res))
    else $error("stalled result changed");

endmodule

bind sccb_register_access_master sccb_checker u_sccb_checker (.*);
